// ===== hw/rtl/nth_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nibble transition histogram package
// Shared widths, operation codes and the memory operation type.
// ----------------------------------------------------------------------------
package nth_pkg;

    localparam int NIBBLE_W = 4;
    localparam int ADDR_W   = 2 * NIBBLE_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int OUT_W    = 32;
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              rd_clr;
        logic [ADDR_W-1:0] addr;
    } mem_op_t;

endpackage : nth_pkg
`default_nettype wire

// ===== hw/rtl/nibble_transition_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nibble transition histogram
// Counts pairs of consecutive nibbles of a byte stream in a 16x16 table of
// saturating counters held in one memory; a read transaction returns one
// counter and clears it.
// ----------------------------------------------------------------------------
// A push makes one counter update for a first byte or the first byte after
// reset and two otherwise, one per update on the memory's single
// read-modify-write path. A read makes one read-and-clear access; its result
// is registered in the result buffer before it is offered on the output.
// Same-entry updates in consecutive cycles are forwarded around the memory.
// Reset clears the per-entry valid flags at once, so no clearing pass is needed, and empties the result buffer.
module nibble_transition_histogram
    import nth_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // data_byte[7:0], row[11:8], col[15:12]
    input  wire [S_DATA_W-1:0]   s_tdata,
    // opcode[0], first_byte[1]
    input  wire [S_USER_W-1:0]   s_tuser,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // count[31:0]
    output logic [OUT_W-1:0]     m_tdata
);

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]       vld_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vld_reg;

    logic [NIBBLE_W-1:0]    prev_lo_reg;
    logic                   have_prev_reg;
    logic                   pend_reg;
    logic [ADDR_W-1:0]      pend_addr_reg;

    mem_op_t                issue_op;
    mem_op_t                b_op_reg;

    logic                   last_wr_reg;
    logic [ADDR_W-1:0]      last_addr_reg;
    logic [COUNT_WIDTH-1:0] last_data_reg;

    logic [OUT_W-1:0]       fifo_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             fifo_cnt_reg;

    logic                   s_acc;
    logic                   op_is_read;
    logic                   first_b;
    logic [NIBBLE_W-1:0]    hi;
    logic [NIBBLE_W-1:0]    lo;
    logic                   two_pairs;
    logic                   pop;
    logic                   push;
    logic [1:0]             occ;
    logic                   space_ok;
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] upd;
    logic [OUT_W-1:0]       cnt_out;

    assign op_is_read = (s_tuser[0] == OP_READ);
    assign first_b    = s_tuser[1];
    assign hi         = s_tdata[7:4];
    assign lo         = s_tdata[3:0];
    assign two_pairs  = !first_b && have_prev_reg;

    assign pop      = m_tvalid && m_tready;
    assign push     = b_op_reg.valid && b_op_reg.rd_clr;
    assign occ      = fifo_cnt_reg + {1'b0, push};
    assign space_ok = pop ? (occ <= 2'd2) : (occ <= 2'd1);
    assign s_tready = !pend_reg && space_ok;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        issue_op = '0;
        if (pend_reg) begin
            issue_op.valid = 1'b1;
            issue_op.addr  = pend_addr_reg;
        end else if (s_acc) begin
            issue_op.valid = 1'b1;
            if (op_is_read) begin
                issue_op.rd_clr = 1'b1;
                issue_op.addr   = {s_tdata[11:8], s_tdata[15:12]};
            end else if (two_pairs) begin
                issue_op.addr = {prev_lo_reg, hi};
            end else begin
                issue_op.addr = {hi, lo};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            prev_lo_reg   <= '0;
            have_prev_reg <= 1'b0;
            b_op_reg      <= '0;
            last_wr_reg   <= 1'b0;
        end else begin
            if (pend_reg) begin
                pend_reg <= 1'b0;
            end else if (s_acc && !op_is_read) begin
                pend_reg      <= two_pairs;
                prev_lo_reg   <= lo;
                have_prev_reg <= 1'b1;
            end
            b_op_reg    <= issue_op;
            last_wr_reg <= b_op_reg.valid;
        end
        if (s_acc) begin
            pend_addr_reg <= {hi, lo};
        end
        last_addr_reg <= b_op_reg.addr;
        last_data_reg <= upd;
    end

    // Memory read on issue, write back in the next cycle from the registered operation.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[issue_op.addr];
        if (b_op_reg.valid) begin
            mem[b_op_reg.addr] <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= vld_reg[issue_op.addr];
            if (b_op_reg.valid) begin
                vld_reg[b_op_reg.addr] <= 1'b1;
            end
        end
    end

    always_comb begin
        priority if (last_wr_reg && (last_addr_reg == b_op_reg.addr)) begin
            cur = last_data_reg;
        end else if (rd_vld_reg) begin
            cur = rd_data_reg;
        end else begin
            cur = '0;
        end
        if (b_op_reg.rd_clr) begin
            upd = '0;
        end else if (&cur) begin
            upd = cur;
        end else begin
            upd = cur + COUNT_WIDTH'(1);
        end
    end

    generate
        if (COUNT_WIDTH > OUT_W) begin : g_sat
            assign cnt_out = (|cur[COUNT_WIDTH-1:OUT_W]) ? {OUT_W{1'b1}} : cur[OUT_W-1:0];
        end else begin : g_ext
            assign cnt_out = OUT_W'(cur);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fifo_cnt_reg <= fifo_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cnt_out;
        end
    end

    assign m_tvalid = (fifo_cnt_reg != 2'd0);
    assign m_tdata  = fifo_reg[rd_ptr_reg];

endmodule : nibble_transition_histogram
`default_nettype wire

// ===== bench/nibble_transition_histogram_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nibble transition histogram testbench
// Drives byte pushes and read-and-clear transactions into the histogram,
// keeps its own copy of the 16x16 counter table and compares every returned
// count with the value predicted for the oldest outstanding read.
// ----------------------------------------------------------------------------
module nibble_transition_histogram_tb;
    import nth_pkg::*;

    localparam int CNT_W      = 32;
    localparam int WDOG_LIMIT = 2000;
    localparam int RAND_ITEMS = 850;
    localparam int QUIET_ITEMS = 150;

    class histogram_scoreboard;
        logic [CNT_W-1:0] pair_tally [DEPTH];
        logic [3:0]       last_low;
        bit               seen_byte;
        logic [OUT_W-1:0] pending_counts [$];
        int               errors;

        function new();
            foreach (pair_tally[k]) pair_tally[k] = '0;
            last_low  = '0;
            seen_byte = 1'b0;
            errors    = 0;
        endfunction

        function void bump(logic [3:0] lead, logic [3:0] follow);
            if (pair_tally[{lead, follow}] != {CNT_W{1'b1}})
                pair_tally[{lead, follow}] = pair_tally[{lead, follow}] + 1'b1;
        endfunction

        function void note_transaction(logic [S_USER_W-1:0] user, logic [S_DATA_W-1:0] data);
            logic [63:0] wide;
            logic [7:0]  idx;
            if (user[0] == OP_PUSH) begin
                if (!user[1] && seen_byte)
                    bump(last_low, data[7:4]);
                bump(data[7:4], data[3:0]);
                last_low  = data[3:0];
                seen_byte = 1'b1;
            end else begin
                idx  = {data[11:8], data[15:12]};
                wide = 64'(pair_tally[idx]);
                pending_counts.push_back((wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0]);
                pair_tally[idx] = '0;
            end
        endfunction

        function void check_count(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (pending_counts.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected count %0d with no read outstanding", $time, got);
                return;
            end
            want = pending_counts.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: count mismatch, expected %0d, actual %0d", $time, want, got);
            end
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    wire                 s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    wire  [OUT_W-1:0]    m_tdata;

    histogram_scoreboard sb = new();
    bit         quiet = 1'b0;
    int         idle_cycles = 0;
    logic [7:0] last_byte = '0;

    nibble_transition_histogram #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_item(input logic [S_USER_W-1:0] user, input logic [S_DATA_W-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_transaction(user, data);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input bit first);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        last_byte = b;
        send_item({first, OP_PUSH}, {junk, b});
    endtask

    task automatic read_entry(input logic [3:0] row, input logic [3:0] col);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send_item({1'($urandom_range(0, 1)), OP_READ}, {col, row, junk});
    endtask

    // Result side: checks accepted counts and, outside the quiet tail, stalls in random bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_count(m_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [7:0] b;
        logic [3:0] r;
        logic [3:0] c;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        read_entry(4'h0, 4'h0);
        push_byte(8'h00, 1'b0);   // no previous byte after reset
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);   // both pairs land on one entry
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b1);
        read_entry(4'h0, 4'h0);
        read_entry(4'hF, 4'hF);
        read_entry(4'hF, 4'hF);
        read_entry(4'hF, 4'hA);
        read_entry(4'hA, 4'h5);
        read_entry(4'h5, 4'hA);
        push_byte(8'h12, 1'b1);
        read_entry(4'h1, 4'h2);   // a read leaves the previous nibble alone
        push_byte(8'h34, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0);
        read_entry(4'h2, 4'h3);
        read_entry(4'h3, 4'h4);
        read_entry(4'h4, 4'h0);
        read_entry(4'hF, 4'hF);
        read_entry(4'h0, 4'h0);
        read_entry(4'h0, 4'hF);

        // Random part.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    r = last_byte[7:4];
                    c = last_byte[3:0];
                end else begin
                    r = 4'($urandom_range(0, 15));
                    c = 4'($urandom_range(0, 15));
                end
                read_entry(r, c);
            end else begin
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1))
                    b = b & 8'h33;
                push_byte(b, $urandom_range(0, 15) == 0);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending_counts.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
